@@ hdl/s2u_pkg.sv @@
package s2u_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_WS     = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } s2u_phase_t;

  // digit bookkeeping
  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_DIGITS = 2'd1,
    ST_OVER   = 2'd2
  } s2u_status_t;

  localparam int CHAR_W   = 8;
  localparam int RADIX_W  = 6;
  localparam int DIGIT_W  = 7;
  localparam int OFFSET_W = 13;

  // one input beat
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } s2u_beat_t;

  // result flags that travel with the value
  typedef struct packed {
    logic                overflowed;
    logic                found_digits;
    logic [OFFSET_W-1:0] end_offset;
  } s2u_flags_t;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;
  localparam logic [DIGIT_W-1:0] LETTER_OFS = 7'd10;

  // radix codes
  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_NONE;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = DIGIT_W'(c - CH_ZERO);
    end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
      d = DIGIT_W'(c - CH_UP_A) + LETTER_OFS;
    end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
      d = DIGIT_W'(c - CH_LO_A) + LETTER_OFS;
    end
    return d;
  endfunction

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
  endfunction

endpackage

@@ hdl/s2u_in_reg.sv @@
module s2u_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  s2u_pkg::s2u_beat_t in_beat,
  input  logic              take,
  output logic              beat_valid,
  output s2u_pkg::s2u_beat_t beat
);

  logic               valid_r;
  s2u_pkg::s2u_beat_t beat_r;
  logic               load;

  // register refills when empty or when the core consumes it
  assign load     = !valid_r || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

@@ hdl/s2u_core.sv @@
module s2u_core #(
  parameter int MAX_LEN     = 4096,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [s2u_pkg::RADIX_W-1:0]   cfg_wr_data,
  input  logic                          beat_valid,
  input  s2u_pkg::s2u_beat_t            beat,
  input  logic                          res_ready,
  output logic                          take,
  output logic                          res_load,
  output logic [VALUE_WIDTH-1:0]        res_value,
  output s2u_pkg::s2u_flags_t           res_flags
);

  localparam int IDX_W  = $clog2(MAX_LEN + 1);
  localparam int PROD_W = VALUE_WIDTH + s2u_pkg::DIGIT_W;

  logic [s2u_pkg::RADIX_W-1:0] radix_r;

  s2u_pkg::s2u_phase_t         phase_r, phase_nxt;
  s2u_pkg::s2u_status_t        status_r, status_nxt;
  logic [VALUE_WIDTH-1:0]      acc_r, acc_nxt;
  logic                        minus_r, minus_nxt;
  logic [s2u_pkg::RADIX_W-1:0] base_r, base_nxt;
  logic [IDX_W-1:0]            cidx_r, cidx_nxt;
  logic [IDX_W-1:0]            stop_r, stop_nxt;

  logic [s2u_pkg::CHAR_W-1:0]  c;
  logic [s2u_pkg::DIGIT_W-1:0] d;
  logic [s2u_pkg::RADIX_W-1:0] dc_base;
  logic                        dc_en;
  logic [VALUE_WIDTH-1:0]      acc_src;
  s2u_pkg::s2u_status_t        st_src;
  logic [PROD_W-1:0]           prod;
  logic                        mac_over;
  s2u_pkg::s2u_status_t        st_fin;
  logic [IDX_W-1:0]            stop_fin;
  logic [31:0]                 stop_ext;

  assign take     = beat_valid && (!beat.is_last || res_ready);
  assign res_load = take && beat.is_last;

  // characters past the length limit read as nul
  assign c = (cidx_r >= IDX_W'(MAX_LEN)) ? s2u_pkg::CH_NUL : beat.char_code;
  assign d = s2u_pkg::digit_of(c);

  // a digit after a leading zero starts from an empty accumulator
  assign acc_src = (phase_r == s2u_pkg::PH_ZERO) ? '0 : acc_r;
  assign st_src  = (phase_r == s2u_pkg::PH_ZERO) ? s2u_pkg::ST_DIGITS : status_r;

  // multiply-add; anything above the value width is overflow
  assign prod     = PROD_W'(acc_src) * PROD_W'(dc_base) + PROD_W'(d);
  assign mac_over = (st_src == s2u_pkg::ST_OVER) ||
                    (prod[PROD_W-1:VALUE_WIDTH] != '0);

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    acc_nxt    = acc_r;
    minus_nxt  = minus_r;
    base_nxt   = base_r;
    cidx_nxt   = cidx_r;
    stop_nxt   = stop_r;
    dc_en      = 1'b0;
    dc_base    = base_r;

    if (cidx_r < IDX_W'(MAX_LEN)) begin
      cidx_nxt = cidx_r + 1'b1;
    end

    case (phase_r)
      s2u_pkg::PH_WS, s2u_pkg::PH_SIGNED: begin
        if (phase_r == s2u_pkg::PH_WS && s2u_pkg::is_space(c)) begin
          phase_nxt = s2u_pkg::PH_WS;
        end else if (phase_r == s2u_pkg::PH_WS && c == s2u_pkg::CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = s2u_pkg::PH_SIGNED;
        end else if (phase_r == s2u_pkg::PH_WS && c == s2u_pkg::CH_PLUS) begin
          phase_nxt = s2u_pkg::PH_SIGNED;
        end else if ((radix_r == s2u_pkg::RADIX_AUTO || radix_r == s2u_pkg::RADIX_HEX) &&
                     c == s2u_pkg::CH_ZERO) begin
          phase_nxt = s2u_pkg::PH_ZERO;
        end else if (radix_r == s2u_pkg::RADIX_AUTO) begin
          dc_base = s2u_pkg::RADIX_DEC;
          dc_en   = 1'b1;
        end else if (radix_r < s2u_pkg::RADIX_MIN || radix_r > s2u_pkg::RADIX_MAX) begin
          phase_nxt = s2u_pkg::PH_DONE;
        end else begin
          dc_base = radix_r;
          dc_en   = 1'b1;
        end
      end
      s2u_pkg::PH_ZERO: begin
        if (c == s2u_pkg::CH_LO_X || c == s2u_pkg::CH_UP_X) begin
          base_nxt  = s2u_pkg::RADIX_HEX;
          phase_nxt = s2u_pkg::PH_DIGITS;
        end else begin
          // the leading zero counts as a digit
          dc_base    = (radix_r == s2u_pkg::RADIX_AUTO) ? s2u_pkg::RADIX_OCT
                                                        : s2u_pkg::RADIX_HEX;
          status_nxt = s2u_pkg::ST_DIGITS;
          acc_nxt    = '0;
          dc_en      = 1'b1;
        end
      end
      s2u_pkg::PH_DIGITS: begin
        dc_en = 1'b1;
      end
      default: begin
      end
    endcase

    if (dc_en) begin
      base_nxt = dc_base;
      if (d >= s2u_pkg::DIGIT_W'(dc_base)) begin
        stop_nxt  = cidx_r;
        phase_nxt = s2u_pkg::PH_DONE;
      end else begin
        phase_nxt = s2u_pkg::PH_DIGITS;
        if (mac_over) begin
          status_nxt = s2u_pkg::ST_OVER;
        end else begin
          status_nxt = s2u_pkg::ST_DIGITS;
          acc_nxt    = prod[VALUE_WIDTH-1:0];
        end
      end
    end

    // end of string closes an open number
    st_fin   = status_nxt;
    stop_fin = stop_nxt;
    if (phase_nxt == s2u_pkg::PH_ZERO) begin
      st_fin   = s2u_pkg::ST_DIGITS;
      stop_fin = cidx_r + 1'b1;
    end else if (phase_nxt == s2u_pkg::PH_DIGITS) begin
      stop_fin = cidx_r + 1'b1;
    end
    stop_ext = 32'(stop_fin);

    if (st_fin == s2u_pkg::ST_OVER) begin
      res_value = '1;
    end else if (minus_nxt) begin
      res_value = '0 - acc_nxt;
    end else begin
      res_value = acc_nxt;
    end
    res_flags.overflowed   = (st_fin == s2u_pkg::ST_OVER);
    res_flags.found_digits = (st_fin != s2u_pkg::ST_NONE);
    res_flags.end_offset   = (st_fin != s2u_pkg::ST_NONE) ?
                             stop_ext[s2u_pkg::OFFSET_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= s2u_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_load) begin
      phase_r  <= s2u_pkg::PH_WS;
      status_r <= s2u_pkg::ST_NONE;
      acc_r    <= '0;
      minus_r  <= 1'b0;
      base_r   <= '0;
      cidx_r   <= '0;
      stop_r   <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      acc_r    <= acc_nxt;
      minus_r  <= minus_nxt;
      base_r   <= base_nxt;
      cidx_r   <= cidx_nxt;
      stop_r   <= stop_nxt;
    end
  end

  a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> res_ready)
    else $error("result loaded while output register full");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (phase_r == s2u_pkg::PH_WS && cidx_r == '0 &&
                  status_r == s2u_pkg::ST_NONE))
    else $error("parse state not cleared after last beat");

  a_over_in_number: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == s2u_pkg::ST_OVER) |->
      (phase_r == s2u_pkg::PH_DIGITS || phase_r == s2u_pkg::PH_DONE))
    else $error("overflow outside digit phase");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cidx_r <= IDX_W'(MAX_LEN)) && (stop_r <= IDX_W'(MAX_LEN)))
    else $error("character index beyond length limit");

endmodule

@@ hdl/s2u_out_reg.sv @@
module s2u_out_reg #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_load,
  input  logic [VALUE_WIDTH-1:0] res_value,
  input  s2u_pkg::s2u_flags_t    res_flags,
  output logic                   res_ready,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_value,
  output s2u_pkg::s2u_flags_t    out_flags
);

  logic                   valid_r;
  logic [VALUE_WIDTH-1:0] value_r;
  s2u_pkg::s2u_flags_t    flags_r;

  assign res_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      value_r <= res_value;
      flags_r <= res_flags;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_flags = flags_r;

endmodule

@@ hdl/string_to_unsigned_parser.sv @@
// path: a beat is held in the input register and parsed from there; a string's result
//   goes into the result register (out_*) as the core takes the string's last beat
// throughput: one character per cycle, set by the single multiply-add per character
//   (accumulator times base plus digit, with the overflow test on the same product);
//   a last beat waits in the input register while the result register is stalled
// reset: synchronous active-low rst_n empties both pipeline registers, returns the
//   parse state to skip-whitespace and sets the radix register to 10
module string_to_unsigned_parser #(
  parameter int MAX_LEN     = 4096,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // radix register write
  input  logic                   cfg_wr_en,
  input  logic [5:0]             cfg_wr_data,
  // character stream
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_char_code,
  input  logic                   in_is_last,
  // one result per string
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic                   out_overflowed,
  output logic                   out_found_digits,
  output logic [12:0]            out_end_offset
);

  s2u_pkg::s2u_beat_t     in_beat;
  s2u_pkg::s2u_beat_t     beat;
  logic                   beat_valid;
  logic                   take;
  logic                   res_load;
  logic                   res_ready;
  logic [VALUE_WIDTH-1:0] res_value;
  s2u_pkg::s2u_flags_t    res_flags;
  s2u_pkg::s2u_flags_t    out_flags;

  // pack the incoming beat
  assign in_beat.char_code = in_char_code;
  assign in_beat.is_last   = in_is_last;

  // input register: takes a new beat when empty or when the core drains the old one
  s2u_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  // parse core: phase machine, accumulator and the radix register;
  // only a last beat has to wait for room in the output register
  s2u_core #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat_valid  (beat_valid),
    .beat        (beat),
    .res_ready   (res_ready),
    .take        (take),
    .res_load    (res_load),
    .res_value   (res_value),
    .res_flags   (res_flags)
  );

  // result register: holds a finished result while the sink stalls
  s2u_out_reg #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res_value (res_value),
    .res_flags (res_flags),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_flags (out_flags)
  );

  // unpack result flags onto their own ports
  assign out_overflowed   = out_flags.overflowed;
  assign out_found_digits = out_flags.found_digits;
  assign out_end_offset   = out_flags.end_offset;

endmodule
